[sv/mel_pkg.sv]
// Shared types and constants for the 1D mesh element locator.
// Used by every module of the block; depends on nothing else.
package mel_pkg;

  // Field widths of the ports
  localparam int COORD_W    = 32;
  localparam int LOAD_IDX_W = 10;
  localparam int ELEM_IDX_W = 10;
  localparam int COUNT_W    = 11;
  localparam int FRAC_BITS  = 16;
  localparam int REF_W      = FRAC_BITS + 2;
  localparam int QUO_W      = FRAC_BITS + 1;

  // Internal arithmetic widths
  localparam int SUM_W = COORD_W + 1;  // c0+c1, c1-c0, q+-a
  localparam int P2_W  = COORD_W + 2;  // 2*(q+-a)
  localparam int N_W   = COORD_W + 3;  // 2p-(c0+c1)

  // Default table depth
  localparam int MAX_ELEMENTS_DEF = 1024;

  // Configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = COUNT_W;
  localparam logic [CFG_IDX_W-1:0] CFG_ELEMENT_COUNT  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SHIFT_SUBTRACT = 1'd1;

  // Operation codes
  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_LOCATE = 1'b1;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DIV,
    ST_FINISH
  } state_t;

  // Per-element test result leaving the evaluation pipe
  typedef struct packed {
    logic               valid;
    logic               hit;
    logic               neg;
    logic [COORD_W-1:0] num_mag;
    logic [COORD_W-1:0] den_mag;
  } eval_t;

endpackage

[sv/mel_table.sv]
// Element coordinate table: one write port, one registered read port.
// Depends on mel_pkg for the coordinate width.
module mel_table #(
  parameter int DEPTH = mel_pkg::MAX_ELEMENTS_DEF,
  parameter int IDX_W = $clog2(DEPTH)
) (
  input  logic                        clk,
  input  logic                        wr_en,
  input  logic [IDX_W-1:0]            wr_addr,
  input  logic [mel_pkg::COORD_W-1:0] wr_left,
  input  logic [mel_pkg::COORD_W-1:0] wr_right,
  input  logic                        rd_en,
  input  logic [IDX_W-1:0]            rd_addr,
  output logic [mel_pkg::COORD_W-1:0] rd_left,
  output logic [mel_pkg::COORD_W-1:0] rd_right
);
  import mel_pkg::*;

  logic [2*COORD_W-1:0] mem [DEPTH];

  // Load port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {wr_right, wr_left};
    end
  end

  // Scan port, registered read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      {rd_right, rd_left} <= mem[rd_addr];
    end
  end

endmodule

[sv/mel_eval.sv]
// Three-stage element test: containment of p in [c0,c1] plus operand prep for xi.
// Depends on mel_pkg for widths and the eval_t result struct.
module mel_eval #(
  parameter int IDX_W = 10
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         flush,
  input  logic                         elem_valid,
  input  logic [IDX_W-1:0]             elem_idx,
  input  logic [mel_pkg::COORD_W-1:0]  c0,
  input  logic [mel_pkg::COORD_W-1:0]  c1,
  input  logic [mel_pkg::P2_W-1:0]     p2,
  output mel_pkg::eval_t               res,
  output logic [IDX_W-1:0]             res_idx,
  output logic                         busy
);
  import mel_pkg::*;

  // stage 1: node sum and element length
  logic             s1_valid;
  logic [IDX_W-1:0] s1_idx;
  logic [SUM_W-1:0] s1_sum;
  logic [SUM_W-1:0] s1_len;

  // stage 2: numerator and length magnitude
  logic               s2_valid;
  logic [IDX_W-1:0]   s2_idx;
  logic [N_W-1:0]     s2_num;
  logic [COORD_W-1:0] s2_den_mag;
  logic               s2_den_nz;
  logic               s2_den_neg;

  logic [SUM_W-1:0] len_abs;
  logic [N_W-1:0]   num_abs;

  assign busy = s1_valid | s2_valid;

  // stage 1 datapath
  always_ff @(posedge clk) begin
    s1_idx <= elem_idx;
    s1_sum <= {c0[COORD_W-1], c0} + {c1[COORD_W-1], c1};
    s1_len <= {c1[COORD_W-1], c1} - {c0[COORD_W-1], c0};
  end

  // stage 2 datapath
  assign len_abs = s1_len[SUM_W-1] ? (~s1_len + 1'b1) : s1_len;

  always_ff @(posedge clk) begin
    s2_idx     <= s1_idx;
    s2_num     <= {p2[P2_W-1], p2} - {{(N_W-SUM_W){s1_sum[SUM_W-1]}}, s1_sum};
    s2_den_mag <= len_abs[COORD_W-1:0];
    s2_den_nz  <= (s1_len != '0);
    s2_den_neg <= s1_len[SUM_W-1];
  end

  // stage 3: |n| <= |d| with nonzero d, plus the valid bits of every stage
  assign num_abs = s2_num[N_W-1] ? (~s2_num + 1'b1) : s2_num;

  always_ff @(posedge clk) begin
    if (rst || flush) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      res.valid <= 1'b0;
    end else begin
      s1_valid  <= elem_valid;
      s2_valid  <= s1_valid;
      res.valid <= s2_valid;
    end
    res_idx     <= s2_idx;
    res.hit     <= s2_den_nz && (num_abs <= {{(N_W-COORD_W){1'b0}}, s2_den_mag});
    res.neg     <= s2_num[N_W-1] ^ s2_den_neg;
    res.num_mag <= num_abs[COORD_W-1:0];
    res.den_mag <= s2_den_mag;
  end

endmodule

[sv/mel_div.sv]
// Restoring serial divider for xi: floor(|n| * 2^FRAC_BITS / |d|), one bit per cycle.
// Depends on mel_pkg; requires |n| <= |d| so the quotient fits FRAC_BITS+1 bits.
module mel_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [mel_pkg::COORD_W-1:0] num_mag,
  input  logic [mel_pkg::COORD_W-1:0] den_mag,
  input  logic                        neg,
  output logic                        done,
  output logic [mel_pkg::REF_W-1:0]   ref_out
);
  import mel_pkg::*;

  localparam int STEP_W = $clog2(QUO_W + 1);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(QUO_W - 1);

  logic              busy;
  logic [STEP_W-1:0] step;
  logic [SUM_W-1:0]  rem;
  logic [COORD_W-1:0] den;
  logic [QUO_W-1:0]  quo;
  logic              sign;

  logic [SUM_W-1:0]  trial;
  logic              ge;
  logic [QUO_W-1:0]  quo_next;
  logic [REF_W-1:0]  mag_ext;

  // first step compares the unshifted remainder, later steps shift in a zero
  assign trial    = (step == '0) ? rem : {rem[SUM_W-2:0], 1'b0};
  assign ge       = trial >= {1'b0, den};
  assign quo_next = {quo[QUO_W-2:0], ge};
  assign mag_ext  = {{(REF_W-QUO_W){1'b0}}, quo_next};

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == LAST_STEP) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= {1'b0, num_mag};
      den  <= den_mag;
      sign <= neg;
      quo  <= '0;
    end else if (busy) begin
      rem <= ge ? (trial - {1'b0, den}) : trial;
      quo <= quo_next;
      if (step == LAST_STEP) begin
        ref_out <= sign ? (~mag_ext + 1'b1) : mag_ext;
      end
    end
  end

endmodule

[sv/mesh_element_locator_1d_top.sv]
// Top level of the 1D mesh element locator: sequencer, config registers, result register.
// Depends on mel_pkg, mel_table, mel_eval and mel_div.
//
// Usage:
//   Request channel (req_valid/req_stall): operation 0 loads element load_index with
//   its two node coordinates; operation 1 locates query_position +/- atom_coordinate.
//   A load gives no response. A locate gives one response on the
//   rsp channel (rsp_valid/rsp_stall): found, element_index and ref_coord (xi, Q1.16).
//   Config channel (cfg_valid/cfg_ready, ready except in reset): index 0 element_count,
//   index 1 shift_subtract. Write it only while no locate is in progress.
// Scan of a locate: the table is scanned one element per cycle through the read
//   port and a three-stage compare pipe; a miss is answered once the last scanned
//   element has left the pipe, and a hit at element k then runs the serial divider.
//   req_stall is high for the whole locate; one locate is in flight at a time.
// Reset clears config registers to zero and the sequencer to idle; the table keeps
//   whatever it held and needs loading before use.
// A stalled response holds in the output register; a new request is still taken,
//   but its result waits until the previous transfer on rsp completes.
module mesh_element_locator_1d_top #(
  parameter int MAX_ELEMENTS = mel_pkg::MAX_ELEMENTS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  // request channel
  input  logic                           req_valid,
  output logic                           req_stall,
  input  logic                           operation,
  input  logic [mel_pkg::LOAD_IDX_W-1:0] load_index,
  input  logic [mel_pkg::COORD_W-1:0]    left_node_coord,
  input  logic [mel_pkg::COORD_W-1:0]    right_node_coord,
  input  logic [mel_pkg::COORD_W-1:0]    query_position,
  input  logic [mel_pkg::COORD_W-1:0]    atom_coordinate,
  // response channel
  output logic                           rsp_valid,
  input  logic                           rsp_stall,
  output logic                           found,
  output logic [mel_pkg::ELEM_IDX_W-1:0] element_index,
  output logic [mel_pkg::REF_W-1:0]      ref_coord,
  // config channel
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [mel_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mel_pkg::CFG_DATA_W-1:0] cfg_data
);
  import mel_pkg::*;

  localparam int IDX_W = $clog2(MAX_ELEMENTS);
  localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_ELEMENTS);

  // config registers
  logic [COUNT_W-1:0] element_count;
  logic               shift_subtract;

  // sequencer
  state_t state, state_next;
  logic [CNT_W-1:0]  issue_cnt;
  logic [CNT_W-1:0]  limit;
  logic [CNT_W-1:0]  limit_next;
  logic [P2_W-1:0]   p2;
  logic [SUM_W-1:0]  point_sum;
  logic              rd_valid;
  logic [IDX_W-1:0]  rd_idx;

  // pending result
  logic              res_found;
  logic [IDX_W-1:0]  res_idx;
  logic [REF_W-1:0]  res_ref;

  // handshake decodes
  logic req_xfer;
  logic load_xfer;
  logic locate_xfer;
  logic load_in_range;
  logic rsp_free;

  // sequencer outputs
  logic issue_en;
  logic hit;
  logic scan_done;
  logic flush;
  logic rsp_load;

  // unit connections
  logic [COORD_W-1:0] rd_left;
  logic [COORD_W-1:0] rd_right;
  eval_t              ev;
  logic [IDX_W-1:0]   ev_idx;
  logic               ev_busy;
  logic               div_done;
  logic [REF_W-1:0]   div_ref;

  assign cfg_ready     = !rst;
  assign req_xfer      = req_valid && !req_stall;
  assign load_xfer     = req_xfer && (operation == OP_LOAD);
  assign locate_xfer   = req_xfer && (operation == OP_LOCATE);
  assign load_in_range = 32'(load_index) < 32'(MAX_ELEMENTS);
  assign rsp_free      = !rsp_valid || !rsp_stall;

  // element count saturated at the table depth
  assign limit_next = (32'(element_count) > 32'(MAX_ELEMENTS)) ? MAX_CNT
                                                               : CNT_W'(element_count);

  // shifted point, doubled
  assign point_sum = shift_subtract
    ? ({query_position[COORD_W-1], query_position} - {atom_coordinate[COORD_W-1], atom_coordinate})
    : ({query_position[COORD_W-1], query_position} + {atom_coordinate[COORD_W-1], atom_coordinate});

  // config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      element_count  <= '0;
      shift_subtract <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_ELEMENT_COUNT:  element_count  <= cfg_data;
        CFG_SHIFT_SUBTRACT: shift_subtract <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (locate_xfer) begin
          state_next = (limit_next == '0) ? ST_FINISH : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (hit) begin
          state_next = ST_DIV;
        end else if (scan_done) begin
          state_next = ST_FINISH;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (rsp_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    req_stall = 1'b1;
    issue_en  = 1'b0;
    hit       = 1'b0;
    scan_done = 1'b0;
    flush     = 1'b0;
    rsp_load  = 1'b0;
    case (state)
      ST_IDLE: begin
        req_stall = rst;  // held off while in reset
        flush     = 1'b1;
      end
      ST_SCAN: begin
        hit       = ev.valid && ev.hit;
        scan_done = (issue_cnt == limit) && !rd_valid && !ev_busy && !ev.valid;
        issue_en  = !hit && (issue_cnt != limit);
        flush     = hit;
      end
      ST_DIV: begin
        flush = 1'b1;
      end
      ST_FINISH: begin
        flush    = 1'b1;
        rsp_load = rsp_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // scan issue counter and read tag
  always_ff @(posedge clk) begin
    if (rst) begin
      issue_cnt <= '0;
      limit     <= '0;
      rd_valid  <= 1'b0;
    end else begin
      rd_valid <= issue_en;
      if (locate_xfer) begin
        issue_cnt <= '0;
        limit     <= limit_next;
      end else if (issue_en) begin
        issue_cnt <= issue_cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue_en) begin
      rd_idx <= issue_cnt[IDX_W-1:0];
    end
    if (locate_xfer) begin
      p2 <= {point_sum, 1'b0};
    end
  end

  // pending result: cleared to a miss on start, filled on hit and divide
  always_ff @(posedge clk) begin
    if (locate_xfer) begin
      res_found <= 1'b0;
      res_idx   <= '0;
      res_ref   <= '0;
    end else if (hit) begin
      res_found <= 1'b1;
      res_idx   <= ev_idx;
    end else if (div_done) begin
      res_ref <= div_ref;
    end
  end

  // response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (rsp_load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_load) begin
      found         <= res_found;
      element_index <= ELEM_IDX_W'(res_idx);
      ref_coord     <= res_ref;
    end
  end

  mel_table #(
    .DEPTH (MAX_ELEMENTS),
    .IDX_W (IDX_W)
  ) u_table (
    .clk      (clk),
    .wr_en    (load_xfer && load_in_range),
    .wr_addr  (IDX_W'(load_index)),
    .wr_left  (left_node_coord),
    .wr_right (right_node_coord),
    .rd_en    (issue_en),
    .rd_addr  (issue_cnt[IDX_W-1:0]),
    .rd_left  (rd_left),
    .rd_right (rd_right)
  );

  mel_eval #(
    .IDX_W (IDX_W)
  ) u_eval (
    .clk        (clk),
    .rst        (rst),
    .flush      (flush),
    .elem_valid (rd_valid),
    .elem_idx   (rd_idx),
    .c0         (rd_left),
    .c1         (rd_right),
    .p2         (p2),
    .res        (ev),
    .res_idx    (ev_idx),
    .busy       (ev_busy)
  );

  mel_div u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (hit),
    .num_mag (ev.num_mag),
    .den_mag (ev.den_mag),
    .neg     (ev.neg),
    .done    (div_done),
    .ref_out (div_ref)
  );

endmodule

[tb/sv/mesh_element_locator_1d_checker.sv]
// Scoreboard for the 1D mesh element locator: watches the request, response and config
// channels, predicts each locate result and compares it field by field.
// Depends on mel_pkg for widths, operation codes and register indexes.
module mesh_element_locator_1d_checker
  import mel_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  input  logic                  req_stall,
  input  logic                  operation,
  input  logic [LOAD_IDX_W-1:0] load_index,
  input  logic [COORD_W-1:0]    left_node_coord,
  input  logic [COORD_W-1:0]    right_node_coord,
  input  logic [COORD_W-1:0]    query_position,
  input  logic [COORD_W-1:0]    atom_coordinate,
  input  logic                  rsp_valid,
  input  logic                  rsp_stall,
  input  logic                  found,
  input  logic [ELEM_IDX_W-1:0] element_index,
  input  logic [REF_W-1:0]      ref_coord,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    mismatch_count,
  output int                    outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic                  found;
    logic [ELEM_IDX_W-1:0] index;
    logic [REF_W-1:0]      xi;
  } location_t;

  // Shadow of the element table and config registers
  logic [COORD_W-1:0] left_nodes  [MAX_ELEMENTS_DEF];
  logic [COORD_W-1:0] right_nodes [MAX_ELEMENTS_DEF];
  logic [COUNT_W-1:0] element_count;
  logic               subtract_mode;

  location_t expected_locations[$];

  // First element (in index order) whose xi falls in [-1,1]; all zero on a miss
  function automatic location_t locate_point(logic [COORD_W-1:0] pos,
                                             logic [COORD_W-1:0] atom);
    location_t         loc;
    longint            twice_p, c0, c1, span, offs;
    longint unsigned   span_mag, offs_mag, quo;
    int                scan_len;
    loc = '0;
    if (subtract_mode)
      twice_p = 2 * (longint'($signed(pos)) - longint'($signed(atom)));
    else
      twice_p = 2 * (longint'($signed(pos)) + longint'($signed(atom)));
    scan_len = (int'(element_count) > MAX_ELEMENTS_DEF) ? MAX_ELEMENTS_DEF
                                                        : int'(element_count);
    for (int i = 0; i < scan_len; i++) begin
      c0   = longint'($signed(left_nodes[i]));
      c1   = longint'($signed(right_nodes[i]));
      span = c1 - c0;
      offs = twice_p - (c0 + c1);
      if (span == 0)
        continue;  // zero-length element never contains anything
      span_mag = (span < 0) ? -span : span;
      offs_mag = (offs < 0) ? -offs : offs;
      if (offs_mag > span_mag)
        continue;
      // magnitude truncates toward zero, sign applied afterwards
      quo = (offs_mag << FRAC_BITS) / span_mag;
      loc.found = 1'b1;
      loc.index = ELEM_IDX_W'(i);
      loc.xi    = ((offs < 0) != (span < 0)) ? REF_W'(-quo) : REF_W'(quo);
      return loc;
    end
    return loc;
  endfunction

  always @(posedge clk) begin
    location_t want;
    if (rst) begin
      element_count = '0;
      subtract_mode = 1'b0;
      expected_locations.delete();
      outstanding   = 0;
    end else begin
      // response transfer: compare against the oldest prediction
      if (rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
        if (expected_locations.size() == 0) begin
          $error("response transfer with no locate outstanding");
          mismatch_count++;
        end else begin
          want = expected_locations.pop_front();
          if (found !== want.found) begin
            $error("found: expected %0d, got %0d", want.found, found);
            mismatch_count++;
          end
          if (element_index !== want.index) begin
            $error("element_index: expected %0d, got %0d", want.index, element_index);
            mismatch_count++;
          end
          if (ref_coord !== want.xi) begin
            $error("ref_coord: expected %0d, got %0d", $signed(want.xi), $signed(ref_coord));
            mismatch_count++;
          end
        end
      end

      // register writes
      if (cfg_valid === 1'b1 && cfg_ready === 1'b1) begin
        case (cfg_index)
          CFG_ELEMENT_COUNT:  element_count = cfg_data[COUNT_W-1:0];
          CFG_SHIFT_SUBTRACT: subtract_mode = cfg_data[0];
          default: ;
        endcase
      end

      // request transfer: loads update the table, locates queue a prediction
      if (req_valid === 1'b1 && req_stall === 1'b0) begin
        if (operation == OP_LOAD) begin
          if (int'(load_index) < MAX_ELEMENTS_DEF) begin
            left_nodes[load_index]  = left_node_coord;
            right_nodes[load_index] = right_node_coord;
          end
        end else begin
          expected_locations.insert(expected_locations.size(),
                                    locate_point(query_position, atom_coordinate));
        end
      end
      outstanding = expected_locations.size();
    end
  end

endmodule

[tb/sv/tb_mesh_element_locator_1d_top.sv]
// Top of the 1D mesh element locator testbench: clock, reset, request and config
// stimulus, response stalls and the final verdict.
// Depends on mel_pkg, mesh_element_locator_1d_top and mesh_element_locator_1d_checker.
module tb_mesh_element_locator_1d_top;
  timeunit 1ns;
  timeprecision 1ps;
  import mel_pkg::*;

  localparam int          RANDOM_ITEMS  = 560;
  localparam int          SETTLE_CYCLES = 8;
  localparam int          DRAIN_CYCLES  = 1100;
  localparam int unsigned LIMIT_CYCLES  = 4_000_000;
  localparam longint      COORD_MAX     = 64'sh7FFF_FFFF;
  localparam longint      COORD_MIN     = -64'sh8000_0000;

  typedef enum logic [1:0] {
    STALL_OFF,
    STALL_RANDOM,
    STALL_STREAKS
  } stall_pattern_t;

  logic                  clk              = 1'b0;
  logic                  rst              = 1'b1;
  logic                  req_valid        = 1'b0;
  logic                  req_stall;
  logic                  operation        = OP_LOAD;
  logic [LOAD_IDX_W-1:0] load_index       = '0;
  logic [COORD_W-1:0]    left_node_coord  = '0;
  logic [COORD_W-1:0]    right_node_coord = '0;
  logic [COORD_W-1:0]    query_position   = '0;
  logic [COORD_W-1:0]    atom_coordinate  = '0;
  logic                  rsp_valid;
  logic                  rsp_stall        = 1'b0;
  logic                  found;
  logic [ELEM_IDX_W-1:0] element_index;
  logic [REF_W-1:0]      ref_coord;
  logic                  cfg_valid        = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index        = CFG_ELEMENT_COUNT;
  logic [CFG_DATA_W-1:0] cfg_data         = '0;
  int                    mismatch_count;
  int                    outstanding;

  // Stimulus-side copy of the node coordinates, used only to aim query points
  logic [COORD_W-1:0] left_img  [MAX_ELEMENTS_DEF];
  logic [COORD_W-1:0] right_img [MAX_ELEMENTS_DEF];
  int                 cur_count;
  logic               cur_subtract;
  int                 burst_left;
  int                 items_sent;
  logic               counting;

  mesh_element_locator_1d_top DUT (.*);

  mesh_element_locator_1d_checker u_checker (.*);

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Watchdog
  int unsigned cycle_count = 0;
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Response stalls: a randomly chosen pattern of off, random or streaks
  stall_pattern_t stall_pattern = STALL_OFF;
  int             pattern_left  = 0;
  int             streak_left   = 0;
  always @(negedge clk) begin
    if (pattern_left == 0) begin
      stall_pattern = stall_pattern_t'($urandom_range(0, 2));
      pattern_left  = $urandom_range(50, 400);
    end else begin
      pattern_left--;
    end
    case (stall_pattern)
      STALL_OFF:    rsp_stall = 1'b0;
      STALL_RANDOM: rsp_stall = ($urandom_range(0, 2) == 0);
      default: begin
        if (streak_left == 0) begin
          rsp_stall   = ~rsp_stall;
          streak_left = $urandom_range(1, 8);
        end else begin
          streak_left--;
        end
      end
    endcase
  end

  // One request transfer, preceded by a random gap at the start of each burst
  task automatic drive_request(input logic op, input logic [LOAD_IDX_W-1:0] idx,
                               input logic [COORD_W-1:0] c0, c1, q, a);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        req_valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    operation        = op;
    load_index       = idx;
    left_node_coord  = c0;
    right_node_coord = c1;
    query_position   = q;
    atom_coordinate  = a;
    req_valid        = 1'b1;
    @(posedge clk);
    while (req_stall !== 1'b0) @(posedge clk);
    @(negedge clk);
    if (counting)
      items_sent++;
  endtask

  task automatic send_load(input int idx, input logic [COORD_W-1:0] c0, c1);
    left_img[idx]  = c0;
    right_img[idx] = c1;
    drive_request(OP_LOAD, LOAD_IDX_W'(idx), c0, c1, $urandom, $urandom);
  endtask

  task automatic send_locate(input logic [COORD_W-1:0] q, a);
    drive_request(OP_LOCATE, LOAD_IDX_W'($urandom), $urandom, $urandom, q, a);
  endtask

  // Extremes, values near the origin, or anything
  function automatic logic [COORD_W-1:0] any_coord();
    case ($urandom_range(0, 7))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return '0;
      3:       return 32'($urandom_range(0, 32'h40_0000)) - 32'h20_0000;
      default: return $urandom;
    endcase
  endfunction

  // Chain of elements sharing nodes, with some zero-length, reversed and wild ones
  task automatic load_mesh(input int first, input int n, input longint start,
                           input int max_width);
    longint x, w;
    x = start;
    for (int k = 0; k < n && first + k < MAX_ELEMENTS_DEF; k++) begin
      case ($urandom_range(0, 15))
        0: w = 0;
        1: w = -longint'($urandom_range(1, max_width));
        2: begin
          x = longint'($signed($urandom));
          w = longint'($signed($urandom));
        end
        default: w = longint'($urandom_range(1, max_width));
      endcase
      send_load(first + k, 32'(x), 32'(x + w));
      x = longint'($signed(32'(x + w)));
    end
  endtask

  // Point inside, on the ends of, or just outside one of the scanned elements
  task automatic aimed_locate();
    int              scan, k;
    longint          lo, hi, span, p, q, a;
    longint unsigned pick;
    scan = (cur_count > MAX_ELEMENTS_DEF) ? MAX_ELEMENTS_DEF : cur_count;
    if (scan == 0) begin
      send_locate(any_coord(), any_coord());
    end else begin
      k  = $urandom_range(0, scan - 1);
      lo = longint'($signed(left_img[k]));
      hi = longint'($signed(right_img[k]));
      if (lo > hi) begin
        span = lo;
        lo   = hi;
        hi   = span;
      end
      span = hi - lo;
      pick = {$urandom, $urandom};
      case ($urandom_range(0, 7))
        0:       p = lo;
        1:       p = hi;
        2:       p = (lo > COORD_MIN) ? lo - 1 : lo;
        3:       p = (hi < COORD_MAX) ? hi + 1 : hi;
        default: p = lo + longint'(pick % (span + 1));
      endcase
      // split p into position and atom so both fit in 32 bits
      case ($urandom_range(0, 2))
        0:       a = 0;
        1:       a = longint'($urandom_range(0, 32'h40_0000)) - 64'sh20_0000;
        default: a = longint'($signed($urandom));
      endcase
      q = cur_subtract ? p + a : p - a;
      if (q > COORD_MAX || q < COORD_MIN) begin
        a = -a;
        q = cur_subtract ? p + a : p - a;
      end
      if (a > COORD_MAX || q > COORD_MAX || q < COORD_MIN) begin
        a = 0;
        q = p;
      end
      send_locate(32'(q), 32'(a));
    end
  endtask

  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_index = idx;
    cfg_data  = data;
    cfg_valid = 1'b1;
    @(posedge clk);
    while (cfg_ready !== 1'b1) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Wait for every locate result, then let trailing loads finish
  task automatic settle_block();
    req_valid  = 1'b0;
    burst_left = 0;
    while (outstanding != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_mode(input int count, input logic subtract);
    logic [CFG_DATA_W-1:0] data;
    settle_block();
    write_cfg(CFG_ELEMENT_COUNT, CFG_DATA_W'(count));
    data    = CFG_DATA_W'($urandom);
    data[0] = subtract;
    write_cfg(CFG_SHIFT_SUBTRACT, data);
    cur_count    = count;
    cur_subtract = subtract;
  endtask

  initial begin
    int     phase, count, pick, r, top_idx;
    logic   deep;
    longint near;
    cur_count    = 0;
    cur_subtract = 1'b0;
    burst_left   = 0;
    items_sent   = 0;
    counting     = 1'b0;
    repeat (6) @(negedge clk);
    rst = 1'b0;

    // Directed: empty scan out of reset
    send_locate('0, '0);
    // unit element, shared node, zero length, reversed, full range both ways
    send_load(0, 32'h0000_0000, 32'h0001_0000);
    send_load(1, 32'h0001_0000, 32'h0002_0000);
    send_load(2, 32'h0003_0000, 32'h0003_0000);
    send_load(3, 32'h0005_0000, 32'h0004_0000);
    send_load(4, 32'h8000_0000, 32'h7FFF_FFFF);
    send_load(5, 32'h7FFF_FFFF, 32'h8000_0000);
    set_mode(6, 1'b0);
    send_locate(32'h0000_0000, 32'h0000_0000);  // left end of element 0
    send_locate(32'h0000_8000, 32'h0000_8000);  // shared node, lower index wins
    send_locate(32'h0001_8000, 32'h0000_0000);  // middle of element 1
    send_locate(32'h0003_0000, 32'h0000_0000);  // zero-length element skipped
    send_locate(32'h0004_4000, 32'h0000_0000);  // reversed element
    send_locate(32'h0000_5555, 32'h0000_0000);  // negative xi in element 0
    send_locate(32'h7FFF_FFFF, 32'h0000_0000);
    send_locate(32'h8000_0000, 32'h0000_0000);
    send_locate(32'h7FFF_FFFF, 32'h7FFF_FFFF);  // sum beyond 32 bits
    send_locate(32'h8000_0000, 32'h8000_0000);
    set_mode(6, 1'b1);
    send_locate(32'h0000_8000, 32'hFFFF_8000);
    send_locate(32'h8000_0000, 32'h7FFF_FFFF);  // difference beyond 32 bits
    send_locate(32'h7FFF_FFFF, 32'h8000_0000);
    send_locate(32'h0000_0000, 32'h0000_0000);

    // Fill the rest of the table so any count can be scanned
    load_mesh(6, MAX_ELEMENTS_DEF - 6, 64'sh2000_0000, 32'h4_0000);

    // Random phases; the first three hit the count extremes
    counting = 1'b1;
    phase    = 0;
    while (items_sent < RANDOM_ITEMS) begin
      case (phase)
        0: count = 2047;
        1: count = 0;
        2: count = MAX_ELEMENTS_DEF;
        default: begin
          pick = $urandom_range(0, 19);
          if (pick == 0)
            count = 0;
          else if (pick == 1)
            count = $urandom_range(MAX_ELEMENTS_DEF, 2047);
          else if (pick < 5)
            count = $urandom_range(17, 64);
          else
            count = $urandom_range(1, 16);
        end
      endcase
      set_mode(count, (phase == 1) ? 1'b1 : 1'($urandom_range(0, 1)));
      deep = (count > 64);
      near = longint'($urandom_range(0, 32'h0200_0000)) - 64'sh0100_0000;
      // long scans: keep the low slots small so hits land deep in the table
      if (deep)
        load_mesh(0, 16, near, 32'h8_0000);
      else if (count > 0 && $urandom_range(0, 7) != 0)
        load_mesh(0, count, near, 32'h8_0000);
      top_idx = deep ? MAX_ELEMENTS_DEF - 1
                     : ((count + 2 < MAX_ELEMENTS_DEF) ? count + 2 : MAX_ELEMENTS_DEF - 1);
      repeat (deep ? 6 : $urandom_range(12, 30)) begin
        r = $urandom_range(0, 9);
        if (r < 7)
          aimed_locate();
        else if (r < 9)
          send_locate(any_coord(), any_coord());
        else
          send_load($urandom_range(0, top_idx), any_coord(), any_coord());
      end
      phase++;
    end

    settle_block();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (outstanding != 0)
      $error("%0d locate results never arrived", outstanding);
    if (mismatch_count == 0 && outstanding == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
